### rtl/core/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]                opcode;
      logic signed [DATA_W-1:0]  push_value;
      logic [POS_W-1:0]          read_position;
   } dq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_value;
      logic [COUNT_W-1:0]        entry_count;
      logic [1:0]                status;
   } dq_rsp_type;

   // Shift controls broadcast to every cell of the row
   typedef struct packed {
      logic shift_right;
      logic shift_left;
   } dq_cell_ctl_type;

endpackage

### rtl/core/dq_cell.sv
// One storage cell of the queue row: holds a word and passes it to a neighbour.
module dq_cell (
   input  logic                                clock,
   input  dq_pkg::dq_cell_ctl_type             ctl,
   input  logic                                load_here,
   input  logic signed [dq_pkg::DATA_W-1:0]    left_data,
   input  logic signed [dq_pkg::DATA_W-1:0]    right_data,
   input  logic signed [dq_pkg::DATA_W-1:0]    push_value,
   output logic signed [dq_pkg::DATA_W-1:0]    data_out
);

   logic signed [dq_pkg::DATA_W-1:0] data_ff;
   logic signed [dq_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift_right) begin
         data_in = left_data;
      end else if (ctl.shift_left) begin
         data_in = right_data;
      end else if (load_here) begin
         data_in = push_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

### rtl/core/double_ended_queue_top.sv
// Top level of the double-ended queue: request decode, cell row and response register.
//
//   channel  ports                         handshake
//   request  start, busy, req_payload      taken when start && !busy
//   response rsp_valid, rsp_payload        one cycle per response, no back-pressure
//
// The response appears the cycle after the request is taken.
// Cell 0 holds the front entry; push front and pop front shift the whole row by one.
// busy stays low, so a request may be taken on every cycle.
// Synchronous reset empties the queue; cell contents are not cleared.
module double_ended_queue_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dq_pkg::dq_req_type   req_payload,
   output logic                 rsp_valid,
   output dq_pkg::dq_rsp_type   rsp_payload
);

   logic [dq_pkg::CNT_W-1:0]          count_ff;
   logic [dq_pkg::CNT_W-1:0]          count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   dq_pkg::dq_rsp_type                rsp_payload_ff;
   dq_pkg::dq_rsp_type                rsp_payload_in;

   logic                              accept;
   logic                              full;
   logic                              empty;
   logic                              load_back;
   dq_pkg::dq_cell_ctl_type           cell_ctl;
   dq_pkg::status_type                status;
   logic signed [dq_pkg::DATA_W-1:0]  read_sel;
   logic signed [dq_pkg::DATA_W-1:0]  cell_data [dq_pkg::DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
   assign empty  = (count_ff == '0);

   // read mux over the row, position counted from the front cell
   always_comb begin
      read_sel = '0;
      for (int i = 0; i < dq_pkg::DEPTH; i++) begin
         if (dq_pkg::CMP_W'(req_payload.read_position) == dq_pkg::CMP_W'(i)) begin
            read_sel = cell_data[i];
         end
      end
   end

   always_comb begin
      count_in             = count_ff;
      cell_ctl.shift_right = 1'b0;
      cell_ctl.shift_left  = 1'b0;
      load_back            = 1'b0;
      status               = dq_pkg::ST_OK;
      rsp_payload_in.read_value = '0;
      case (dq_pkg::op_type'(req_payload.opcode))
         dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status = dq_pkg::ST_FULL;
            end else begin
               cell_ctl.shift_right = accept;
               count_in             = count_ff + dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status = dq_pkg::ST_FULL;
            end else begin
               load_back = accept;
               count_in  = count_ff + dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status = dq_pkg::ST_EMPTY;
            end else begin
               cell_ctl.shift_left = accept;
               count_in            = count_ff - dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::OP_POP_BACK: begin
            if (empty) begin
               status = dq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::OP_READ: begin
            if (dq_pkg::CMP_W'(req_payload.read_position) >= dq_pkg::CMP_W'(count_ff)) begin
               status = dq_pkg::ST_RANGE;
            end else begin
               rsp_payload_in.read_value = read_sel;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         count_in = count_ff;
      end
      rsp_payload_in.entry_count = dq_pkg::COUNT_W'(count_in);
      rsp_payload_in.status      = status;
      rsp_valid_in               = accept;
   end

   genvar g;
   generate
      for (g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
         logic signed [dq_pkg::DATA_W-1:0] left_data;
         logic signed [dq_pkg::DATA_W-1:0] right_data;
         logic                             load_here;

         if (g == 0) begin : g_front
            assign left_data = req_payload.push_value;
         end else begin : g_inner_l
            assign left_data = cell_data[g-1];
         end
         if (g == dq_pkg::DEPTH - 1) begin : g_back
            assign right_data = cell_data[g];
         end else begin : g_inner_r
            assign right_data = cell_data[g+1];
         end
         assign load_here = load_back && (count_ff == dq_pkg::CNT_W'(g));

         dq_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .load_here  (load_here),
            .left_data  (left_data),
            .right_data (right_data),
            .push_value (req_payload.push_value),
            .data_out   (cell_data[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("request taken without a response");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
      else $error("entry count above depth");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count moved without a request");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == dq_pkg::ST_FULL)
      |-> (rsp_payload.entry_count == dq_pkg::COUNT_W'(dq_pkg::DEPTH)))
      else $error("full status with queue not full");

endmodule

### test/tb_top.sv
// Self-checking testbench for the double-ended queue against a shadow ring buffer.
`timescale 1ns / 100ps

module tb_top;
   import dq_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_REQS = 340;

   typedef struct {
      dq_req_type req;
      bit         drain_first;
   } backlog_item_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       start       = 1'b0;
   dq_req_type req_payload = '0;
   logic       busy;
   logic       rsp_valid;
   dq_rsp_type rsp_payload;

   backlog_item_type request_backlog[$];
   dq_rsp_type       predicted_rsps[$];

   // shadow model of the queue contents, held as a ring buffer
   logic signed [DATA_W-1:0] ring_words [DEPTH];
   int head_slot;
   int fill_level;

   logic req_taken = 1'b0;
   int   issued_reqs;
   int   stall_cycles;
   int   errors;

   double_ended_queue_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic dq_rsp_type apply_deque_op(dq_req_type r);
      dq_rsp_type res;
      res = '0;
      case (r.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (r.opcode == OP_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  ring_words[head_slot] = r.push_value;
               end else begin
                  ring_words[(head_slot + fill_level) % DEPTH] = r.push_value;
               end
               fill_level++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (fill_level == 0) begin
               res.status = ST_EMPTY;
            end else begin
               if (r.opcode == OP_POP_FRONT) head_slot = (head_slot + 1) % DEPTH;
               fill_level--;
            end
         end
         OP_READ: begin
            if (int'(r.read_position) >= fill_level) begin
               res.status = ST_RANGE;
            end else begin
               res.read_value = ring_words[(head_slot + int'(r.read_position)) % DEPTH];
            end
         end
         default: ;  // unused opcodes leave everything as it is
      endcase
      res.entry_count = COUNT_W'(fill_level);
      return res;
   endfunction

   task automatic queue_req(logic [2:0] op, logic signed [DATA_W-1:0] value,
                            logic [POS_W-1:0] pos, bit drain_first = 1'b0);
      backlog_item_type entry;
      entry.req.opcode        = op;
      entry.req.push_value    = value;
      entry.req.read_position = pos;
      entry.drain_first       = drain_first;
      request_backlog.push_back(entry);
   endtask

   // push_pct biases the mix towards filling or draining
   function automatic logic [2:0] pick_op(int push_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < push_pct) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (roll < push_pct + 25) return OP_READ;
      return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   initial begin
      int valid_reqs;
      int push_pct;

      // empty queue, extremes of the data, out-of-range reads, unused opcodes
      queue_req(OP_POP_FRONT, '0, '0);
      queue_req(OP_POP_BACK, '0, '0);
      queue_req(OP_READ, '0, '0);
      queue_req(OP_PUSH_FRONT, 32'sh7fffffff, '0);
      queue_req(OP_PUSH_BACK, 32'sh80000000, '1);
      queue_req(OP_PUSH_FRONT, '1, '0);
      queue_req(OP_PUSH_BACK, '0, '1);
      for (int k = 0; k < 5; k++) queue_req(OP_READ, '0, POS_W'(k));
      queue_req(OP_READ, '0, '1);
      for (int k = OP_READ + 1; k < 8; k++) queue_req(3'(k), '1, '1);
      queue_req(OP_POP_FRONT, '0, '0);
      queue_req(OP_POP_BACK, '0, '0);
      queue_req(OP_READ, '0, 4'd0);
      queue_req(OP_READ, '0, 4'd1);
      queue_req(OP_READ, '0, 4'd2);

      // fill past full, read the far end, then drain past empty
      for (int k = 0; k < DEPTH + 1; k++)
         queue_req($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom, '0);
      queue_req(OP_READ, '0, '1);
      queue_req(OP_READ, '0, POS_W'($urandom_range(15)));
      for (int k = 0; k < DEPTH + 1; k++)
         queue_req($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, $urandom, '0, k == 0);

      valid_reqs = 0;
      push_pct   = 40;
      while (valid_reqs < RANDOM_REQS) begin
         if (valid_reqs % 40 == 0) push_pct = 15 + 25 * $urandom_range(2);
         if ($urandom_range(49) == 0) begin
            queue_req(3'($urandom_range(7, OP_READ + 1)), $urandom, POS_W'($urandom));
         end else begin
            queue_req(pick_op(push_pct), $urandom, POS_W'($urandom_range(15)),
                      valid_reqs == RANDOM_REQS / 2);
            valid_reqs++;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      do @(negedge clock); while (request_backlog.size() != 0 || (start && !req_taken));
      while (predicted_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // hold the request until it is taken
      end else if (request_backlog.size() == 0 ||
                   (request_backlog[0].drain_first && predicted_rsps.size() != 0) ||
                   (!(issued_reqs >= 120 && issued_reqs < 200) &&
                    $urandom_range(99) < 36)) begin
         start <= 1'b0;
      end else begin
         start       <= 1'b1;
         req_payload <= request_backlog[0].req;
         void'(request_backlog.pop_front());
         issued_reqs <= issued_reqs + 1;
      end
   end

   // response monitor and predictor
   always @(posedge clock) begin
      dq_rsp_type want;
      if (reset) begin
         head_slot  = 0;
         fill_level = 0;
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (predicted_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %p", $time, rsp_payload);
               errors++;
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_payload.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %0d, got %0d",
                           $time, want.read_value, rsp_payload.read_value);
                  errors++;
               end
               if (rsp_payload.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d, got %0d",
                           $time, want.entry_count, rsp_payload.entry_count);
                  errors++;
               end
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_payload.status);
                  errors++;
               end
            end
         end
         if (start && !busy) predicted_rsps.push_back(apply_deque_op(req_payload));
         req_taken <= start && !busy;
      end
   end

   // watchdog on cycles with no request taken and no response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
